### sv/assertion_token_validator_macros.svh
// Assertion helpers for the token validator checker.
`ifndef ASSERTION_TOKEN_VALIDATOR_MACROS_SVH
`define ASSERTION_TOKEN_VALIDATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ATV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token validator check failed");

// next-cycle implication
`define ATV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token validator check failed");

`endif

### sv/atv_pkg.sv
`default_nettype none
package atv_pkg;

  localparam int MAX_PAYLOAD  = 2048;
  localparam int MAX_ISSUER   = 128;
  localparam int MAX_SUBJECT  = 256;
  localparam int MAX_AUDIENCE = 128;
  localparam int MAX_PROXY    = 128;
  localparam int SIG_HEX_LEN  = 64;

  localparam int BC_W   = $clog2(MAX_PAYLOAD + 2);
  localparam int VLEN_W = 9;
  localparam int KEY_W  = 40;

  localparam logic [2:0] F_NONE  = 3'd0;
  localparam logic [2:0] F_ISS   = 3'd1;
  localparam logic [2:0] F_SUB   = 3'd2;
  localparam logic [2:0] F_AUD   = 3'd3;
  localparam logic [2:0] F_PROXY = 3'd4;
  localparam logic [2:0] F_EXP   = 3'd5;
  localparam logic [2:0] F_SIG   = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERSIZE  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ   = 8'h3D;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  field_tag;
    logic        is_value;
    logic        done_res;
    logic [1:0]  status;
    logic [63:0] expiry;
  } res_t;

endpackage
`default_nettype wire

### sv/assertion_token_validator.sv
// Assertion token validator.
// Input channel: one payload byte per word (in_byte) with in_last on the
// final byte, valid/ready handshake. Output channel: one word per input
// byte, the byte echoed with its field tag and value flag; on the word for
// the last byte out_done_res is high and out_status / out_expiry carry the
// verdict (expiry is zero unless the payload is accepted).
// Path: a byte accepted at the input is held in the input register, then
// parsed into the output register once that register is empty or being
// drained, and its word is offered from there.
// Throughput: one byte per cycle while out_ready stays high; the parse step
// updates the running key/value state as each byte enters the output word.
// Reset: synchronous, active low; empties both registers and clears the
// parse state. The parse state also clears itself after each last byte.
// Stall: when out_ready is low the output word holds; the input register
// keeps one more byte, then in_ready drops until the output drains.
`default_nettype none
module assertion_token_validator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_field_tag,
  output logic             out_is_value,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic [63:0]      out_expiry
);
  import atv_pkg::*;

  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       out_v_r;
  res_t       res;
  res_t       out_r;

  assign s1_go    = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  atv_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .c     (s1_byte_r),
    .last  (s1_last_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) out_r <= res;
  end

  assign out_valid     = out_v_r;
  assign out_byte      = out_r.out_byte;
  assign out_field_tag = out_r.field_tag;
  assign out_is_value  = out_r.is_value;
  assign out_done_res  = out_r.done_res;
  assign out_status    = out_r.status;
  assign out_expiry    = out_r.expiry;

endmodule
`default_nettype wire

### sv/atv_core.sv
`default_nettype none
module atv_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   c,
  input  wire logic         last,
  output atv_pkg::res_t     res
);
  import atv_pkg::*;

  logic [BC_W-1:0]   bc_r, bc_nxt;
  logic              inval_r, inval_nxt;
  logic [KEY_W-1:0]  kc_r, kc_nxt;
  logic [2:0]        klen_r, klen_nxt;
  logic [2:0]        cur_r, cur_nxt;
  logic [VLEN_W-1:0] vlen_r, vlen_nxt;
  logic [5:0]        seen_r, seen_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              mal_r, mal_nxt;
  logic              over_r, over_nxt;

  function automatic logic payload_ok(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                      8'h3A, 8'h3D, 8'h3B, 8'h5F, 8'h2D, 8'h2E, 8'h2C};
  endfunction

  function automatic logic token_ok(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                      8'h5F, 8'h2D, 8'h2E, 8'h3A, 8'h2F, 8'h40};
  endfunction

  function automatic logic hex_ok(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39], [8'h61:8'h66]};
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[8'h30:8'h39]};
  endfunction

  logic [2:0]        fkey;
  logic [5:0]        fbit;
  logic [VLEN_W:0]   vlen_inc;
  logic              over_lim;
  logic [67:0]       acc_wide;
  logic [2:0]        tag;
  logic              isval;
  logic [1:0]        status;

  // key lookup on the packed first five key characters
  always_comb begin
    fkey = F_NONE;
    if (klen_r == 3'd3) begin
      case (kc_r)
        40'h0000697373: fkey = F_ISS;
        40'h0000737562: fkey = F_SUB;
        40'h0000617564: fkey = F_AUD;
        40'h0000657870: fkey = F_EXP;
        40'h0000736967: fkey = F_SIG;
        default:        fkey = F_NONE;
      endcase
    end else if (klen_r == 3'd5 && kc_r == 40'h70726F7879) begin
      fkey = F_PROXY;
    end
  end

  assign fbit     = 6'b1 << (fkey - 3'd1);
  assign vlen_inc = {1'b0, vlen_r} + 10'd1;

  always_comb begin
    case (cur_r)
      F_ISS:   over_lim = vlen_inc > 10'(MAX_ISSUER);
      F_SUB:   over_lim = vlen_inc > 10'(MAX_SUBJECT);
      F_AUD:   over_lim = vlen_inc > 10'(MAX_AUDIENCE);
      F_PROXY: over_lim = vlen_inc > 10'(MAX_PROXY);
      F_SIG:   over_lim = vlen_inc > 10'(SIG_HEX_LEN);
      default: over_lim = 1'b0;
    endcase
  end

  // acc*10 + digit; any carry into the top nibble is an overflow
  assign acc_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, c[3:0]};

  always_comb begin
    bc_nxt    = bc_r;
    inval_nxt = inval_r;
    kc_nxt    = kc_r;
    klen_nxt  = klen_r;
    cur_nxt   = cur_r;
    vlen_nxt  = vlen_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    mal_nxt   = mal_r;
    over_nxt  = over_r;
    tag       = F_NONE;
    isval     = 1'b0;
    status    = ST_OK;

    if (bc_r < BC_W'(MAX_PAYLOAD + 1)) bc_nxt = bc_r + BC_W'(1);
    if (bc_nxt > BC_W'(MAX_PAYLOAD)) over_nxt = 1'b1;
    if (!payload_ok(c)) mal_nxt = 1'b1;

    if (!inval_r) begin
      if (c == CH_SEMI) begin
        mal_nxt = 1'b1;
      end else if (c == CH_EQ) begin
        if (fkey == F_NONE) begin
          mal_nxt = 1'b1;
        end else begin
          if ((seen_r & fbit) != 6'b0) mal_nxt = 1'b1;
          seen_nxt = seen_r | fbit;
        end
        tag       = fkey;
        cur_nxt   = fkey;
        inval_nxt = 1'b1;
        vlen_nxt  = '0;
        if (fkey == F_EXP) acc_nxt = '0;
      end else if (klen_r < 3'd5) begin
        kc_nxt   = {kc_r[KEY_W-9:0], c};
        klen_nxt = klen_r + 3'd1;
      end else begin
        klen_nxt = 3'd6;
      end
    end else if (c == CH_SEMI) begin
      if (vlen_r == '0) mal_nxt = 1'b1;
      if (cur_r == F_SIG && vlen_r != VLEN_W'(SIG_HEX_LEN)) mal_nxt = 1'b1;
      inval_nxt = 1'b0;
      kc_nxt    = '0;
      klen_nxt  = '0;
      cur_nxt   = F_NONE;
      vlen_nxt  = '0;
    end else begin
      tag   = cur_r;
      isval = 1'b1;
      if (over_lim) mal_nxt = 1'b1;
      vlen_nxt = vlen_inc[VLEN_W] ? '1 : vlen_inc[VLEN_W-1:0];
      if (cur_r == F_EXP) begin
        if (!is_digit(c)) mal_nxt = 1'b1;
        else if (acc_wide[67:64] != 4'b0) mal_nxt = 1'b1;
        else acc_nxt = acc_wide[63:0];
      end else if (cur_r == F_SIG) begin
        if (!hex_ok(c)) mal_nxt = 1'b1;
      end else if (cur_r != F_NONE) begin
        if (!token_ok(c)) mal_nxt = 1'b1;
      end
    end

    if (last) begin
      if (inval_nxt) begin
        if (vlen_nxt == '0) mal_nxt = 1'b1;
        if (cur_nxt == F_SIG && vlen_nxt != VLEN_W'(SIG_HEX_LEN)) mal_nxt = 1'b1;
      end else if (klen_nxt != 3'd0) begin
        mal_nxt = 1'b1;
      end
      if (seen_nxt != 6'h3F || acc_nxt == 64'd0) mal_nxt = 1'b1;
      status = over_nxt ? ST_OVERSIZE : (mal_nxt ? ST_MALFORMED : ST_OK);
    end
  end

  assign res.out_byte  = c;
  assign res.field_tag = tag;
  assign res.is_value  = isval;
  assign res.done_res  = last;
  assign res.status    = status;
  assign res.expiry    = (last && status == ST_OK) ? acc_nxt : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      bc_r    <= '0;
      inval_r <= 1'b0;
      kc_r    <= '0;
      klen_r  <= '0;
      cur_r   <= F_NONE;
      vlen_r  <= '0;
      seen_r  <= '0;
      acc_r   <= '0;
      mal_r   <= 1'b0;
      over_r  <= 1'b0;
    end else if (step) begin
      bc_r    <= bc_nxt;
      inval_r <= inval_nxt;
      kc_r    <= kc_nxt;
      klen_r  <= klen_nxt;
      cur_r   <= cur_nxt;
      vlen_r  <= vlen_nxt;
      seen_r  <= seen_nxt;
      acc_r   <= acc_nxt;
      mal_r   <= mal_nxt;
      over_r  <= over_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/atv_checker.sv
`default_nettype none
`include "assertion_token_validator_macros.svh"
module atv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        out_is_value,
  input wire logic        out_done_res,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_expiry
);
  import atv_pkg::*;

  // a stalled output word holds
  `ATV_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_status))

  // verdict fields are quiet on every word but the last of a payload
  `ATV_ASSERT_IMP(a_mid_quiet, out_valid && !out_done_res, out_status == ST_OK && out_expiry == 64'd0)

  // a rejected payload never reports an expiry
  `ATV_ASSERT_IMP(a_rej_noexp, out_valid && out_status != ST_OK, out_expiry == 64'd0)

  // an accepted payload always has a non-zero expiry
  `ATV_ASSERT_IMP(a_acc_exp, out_valid && out_done_res && out_status == ST_OK, out_expiry != 64'd0)

  // ';' always closes a value, so a value byte is never ';'
  `ATV_ASSERT_IMP(a_val_sep, out_valid && out_is_value, out_byte != CH_SEMI)

endmodule

bind assertion_token_validator atv_checker u_atv_checker (.*);
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import atv_pkg::*;

  localparam int QUIET_TAIL = 100;
  localparam string TOK_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.:";
  localparam string HEX_SET = "0123456789abcdef";

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         pause;
  } stream_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [2:0]  out_field_tag;
  logic        out_is_value;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic [63:0] out_expiry;

  stream_word_t stream_q[$];
  logic [7:0]   payload_buf[$];
  res_t         echo_q[$];

  string key_names[6] = '{"iss", "sub", "aud", "proxy", "exp", "sig"};
  int    field_cap[4] = '{MAX_ISSUER, MAX_SUBJECT, MAX_AUDIENCE, MAX_PROXY};

  // parser copy kept by the testbench
  logic [BC_W-1:0]   pr_count;
  logic              pr_in_value;
  logic [KEY_W-1:0]  pr_key;
  logic [2:0]        pr_klen;
  logic [2:0]        pr_field;
  logic [VLEN_W-1:0] pr_vlen;
  logic [5:0]        pr_seen;
  logic [63:0]       pr_exp;
  logic              pr_bad;
  logic              pr_big;

  int fail_cnt = 0;
  int words_sent = 0;
  int words_seen = 0;
  int n_payloads = 0;
  int n_ok = 0;
  int n_big = 0;
  int n_bad = 0;
  int gap_left = 0;
  int stall_left = 0;
  int rand_start;
  stream_word_t nxt;
  res_t want;

  assertion_token_validator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_field_tag(out_field_tag),
    .out_is_value (out_is_value),
    .out_done_res (out_done_res),
    .out_status   (out_status),
    .out_expiry   (out_expiry)
  );

  always #1 clk = ~clk;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit payload_ok(logic [7:0] c);
    return is_alnum(c) || c == ":" || c == CH_EQ || c == CH_SEMI || c == "_" ||
           c == "-" || c == "." || c == ",";
  endfunction

  function automatic bit token_ok(logic [7:0] c);
    return is_alnum(c) || c == "_" || c == "-" || c == "." || c == ":" ||
           c == "/" || c == "@";
  endfunction

  function automatic void clear_parser();
    pr_count = '0;
    pr_in_value = 1'b0;
    pr_key = '0;
    pr_klen = '0;
    pr_field = F_NONE;
    pr_vlen = '0;
    pr_seen = '0;
    pr_exp = '0;
    pr_bad = 1'b0;
    pr_big = 1'b0;
  endfunction

  function automatic void close_value();
    if (pr_vlen == 0) pr_bad = 1'b1;
    if (pr_field == F_SIG && pr_vlen != SIG_HEX_LEN) pr_bad = 1'b1;
    pr_in_value = 1'b0;
    pr_key = '0;
    pr_klen = '0;
    pr_field = F_NONE;
    pr_vlen = '0;
  endfunction

  // Advances the parser copy by one byte and returns the echo word it owes.
  function automatic res_t parse_byte(logic [7:0] c, logic fin);
    res_t r;
    logic [2:0] f;
    logic [63:0] d;
    int lim;
    r = '0;
    r.out_byte = c;
    r.done_res = fin;
    if (pr_count < MAX_PAYLOAD + 1) pr_count++;
    if (pr_count > MAX_PAYLOAD) pr_big = 1'b1;
    if (!payload_ok(c)) pr_bad = 1'b1;
    if (!pr_in_value) begin
      if (c == CH_SEMI) begin
        pr_bad = 1'b1;
      end else if (c == CH_EQ) begin
        f = F_NONE;
        if (pr_klen == 3) begin
          case (pr_key)
            {16'h0, "iss"}: f = F_ISS;
            {16'h0, "sub"}: f = F_SUB;
            {16'h0, "aud"}: f = F_AUD;
            {16'h0, "exp"}: f = F_EXP;
            {16'h0, "sig"}: f = F_SIG;
            default: f = F_NONE;
          endcase
        end else if (pr_klen == 5 && pr_key == "proxy") begin
          f = F_PROXY;
        end
        if (f == F_NONE) begin
          pr_bad = 1'b1;
        end else begin
          if (pr_seen[f - 1]) pr_bad = 1'b1;
          pr_seen[f - 1] = 1'b1;
        end
        r.field_tag = f;
        pr_field = f;
        pr_in_value = 1'b1;
        pr_vlen = '0;
        if (f == F_EXP) pr_exp = '0;
      end else if (pr_klen < 5) begin
        pr_key = {pr_key[KEY_W-9:0], c};
        pr_klen++;
      end else begin
        pr_klen = 3'd6;
      end
    end else if (c == CH_SEMI) begin
      close_value();
    end else begin
      r.field_tag = pr_field;
      r.is_value = 1'b1;
      case (pr_field)
        F_ISS:   lim = MAX_ISSUER;
        F_SUB:   lim = MAX_SUBJECT;
        F_AUD:   lim = MAX_AUDIENCE;
        F_PROXY: lim = MAX_PROXY;
        F_SIG:   lim = SIG_HEX_LEN;
        default: lim = 1 << 20;
      endcase
      if (int'(pr_vlen) + 1 > lim) pr_bad = 1'b1;
      if (pr_vlen != '1) pr_vlen++;
      case (pr_field)
        F_EXP: begin
          if (!is_digit(c)) begin
            pr_bad = 1'b1;
          end else begin
            d = 64'(c - "0");
            // exact overflow test; accumulator keeps the last good value
            if (pr_exp > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) pr_bad = 1'b1;
            else pr_exp = pr_exp * 10 + d;
          end
        end
        F_SIG: if (!(is_digit(c) || (c >= "a" && c <= "f"))) pr_bad = 1'b1;
        F_NONE: ;
        default: if (!token_ok(c)) pr_bad = 1'b1;
      endcase
    end
    if (fin) begin
      if (pr_in_value) close_value();
      else if (pr_klen != 0) pr_bad = 1'b1;
      if (pr_seen != 6'h3F || pr_exp == 0) pr_bad = 1'b1;
      r.status = pr_big ? ST_OVERSIZE : (pr_bad ? ST_MALFORMED : ST_OK);
      if (r.status == ST_OK) r.expiry = pr_exp;
      clear_parser();
    end
    return r;
  endfunction

  function automatic string pick_chars(int n, string set);
    string s;
    int i, p;
    s = "";
    for (i = 0; i < n; i++) begin
      p = $urandom_range(0, set.len() - 1);
      s = {s, set.substr(p, p)};
    end
    return s;
  endfunction

  function automatic void put(string s);
    int i;
    for (i = 0; i < s.len(); i++) payload_buf.push_back(s[i]);
  endfunction

  function automatic void ship();
    int i;
    for (i = 0; i < payload_buf.size(); i++)
      stream_q.push_back('{data: payload_buf[i], last: i == payload_buf.size() - 1,
                           pause: 1'b0});
    if (payload_buf.size() > 0) n_payloads++;
    payload_buf.delete();
  endfunction

  function automatic void hold_for_drain();
    stream_q.push_back('{data: 8'h00, last: 1'b0, pause: 1'b1});
  endfunction

  // all six keys in tag order; field k (0..5) gets value v, k < 0 keeps defaults
  function automatic void std_token(int k, string v);
    string vals[6];
    int i;
    vals = '{"iss0", "sub-1", "aud.x", "p:y", "42", ""};
    vals[5] = pick_chars(SIG_HEX_LEN, HEX_SET);
    if (k >= 0) vals[k] = v;
    for (i = 0; i < 6; i++) begin
      if (i > 0) put(";");
      put({key_names[i], "=", vals[i]});
    end
  endfunction

  function automatic string good_value(int k);
    logic [63:0] v;
    if (k < 4)
      return pick_chars($urandom_range(0, 49) == 0 ? field_cap[k] : $urandom_range(1, 10),
                        TOK_SET);
    if (k == 5) return pick_chars(SIG_HEX_LEN, HEX_SET);
    case ($urandom_range(0, 3))
      0: return {"00", $sformatf("%0d", $urandom_range(1, 999))};
      1: v = 64'hFFFF_FFFF_FFFF_FFFF;
      default: v = {$urandom, $urandom} | 64'd1;
    endcase
    return $sformatf("%0d", v);
  endfunction

  // kind 0: well formed, 1: one defect, 2: random noise
  function automatic void rand_token(int kind);
    string kname[6];
    string val[6];
    int ord[6];
    int i, j, k, m, tmp, skip, no_eq, pos;
    bit dup, first;
    if (kind == 2) begin
      k = $urandom_range(1, 30);
      for (i = 0; i < k; i++) begin
        if ($urandom_range(0, 1)) payload_buf.push_back(8'($urandom_range(0, 255)));
        else put(pick_chars(1, "=;ab9"));
      end
      ship();
      return;
    end
    for (i = 0; i < 6; i++) begin
      ord[i] = i;
      kname[i] = key_names[i];
      val[i] = good_value(i);
    end
    for (i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ord[i];
      ord[i] = ord[j];
      ord[j] = tmp;
    end
    skip = -1;
    no_eq = -1;
    dup = 1'b0;
    j = $urandom_range(0, 5);
    m = (kind == 1) ? $urandom_range(0, 9) : -1;
    case (m)
      0: skip = j;
      1: dup = 1'b1;
      2: val[j] = "";
      3: begin
        case ($urandom_range(0, 3))
          0: kname[j] = "ISS";
          1: kname[j] = "proxyy";
          2: kname[j] = pick_chars($urandom_range(1, 2), "abcxyz");
          default: kname[j] = "";
        endcase
      end
      4: begin
        case ($urandom_range(0, 3))
          0: val[4] = "0";
          1: val[4] = "18446744073709551616";
          2: val[4] = {"1844674407370955161", pick_chars(1, "56789")};
          default: val[4] = "12e4";
        endcase
      end
      5: begin
        if ($urandom_range(0, 1))
          val[5] = pick_chars(SIG_HEX_LEN + ($urandom_range(0, 1) ? 1 : -1), HEX_SET);
        else
          val[5] = {pick_chars(SIG_HEX_LEN - 1, HEX_SET), "G"};
      end
      6: begin
        k = $urandom_range(0, 3);
        val[k] = pick_chars(field_cap[k] + $urandom_range(1, 3), TOK_SET);
      end
      7: val[j] = {val[j], "=", val[j]};
      8: no_eq = j;
      default: ;
    endcase
    first = 1'b1;
    for (i = 0; i < 6; i++) begin
      k = ord[i];
      if (k != skip) begin
        if (!first) put(";");
        first = 1'b0;
        put(kname[k]);
        if (k != no_eq) put("=");
        put(val[k]);
      end
    end
    if (dup) put({";", kname[j], "=", val[j]});
    if ($urandom_range(0, 2) == 0) put(";");
    if (m == 9) begin
      pos = $urandom_range(0, payload_buf.size() - 1);
      if ($urandom_range(0, 1)) payload_buf[pos] = 8'($urandom_range(0, 255));
      else while (payload_buf.size() > pos + 1) void'(payload_buf.pop_back());
    end
    ship();
  endfunction

  function automatic void report(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        echo_q.push_back(parse_byte(in_byte, in_last));
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0 && stream_q[0].pause) begin
          in_valid <= 1'b0;
          if (echo_q.size() == 0) void'(stream_q.pop_front());
        end else if (stream_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          nxt = stream_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.data;
          in_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (echo_q.size() == 0) begin
          $error("output word with nothing expected: byte %0h", out_byte);
          fail_cnt++;
        end else begin
          want = echo_q.pop_front();
          report("out_byte", want.out_byte, out_byte);
          report("out_field_tag", want.field_tag, out_field_tag);
          report("out_is_value", want.is_value, out_is_value);
          report("out_done_res", want.done_res, out_done_res);
          report("out_status", want.status, out_status);
          report("out_expiry", want.expiry, out_expiry);
          words_seen++;
          if (want.done_res) begin
            case (want.status)
              ST_OK:       n_ok++;
              ST_OVERSIZE: n_big++;
              default:     n_bad++;
            endcase
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stream_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int i;
    clear_parser();

    std_token(4, "18446744073709551615");
    put(";");
    ship();
    for (i = 0; i < 4; i++) begin
      std_token(i, pick_chars(field_cap[i], TOK_SET));
      ship();
    end
    std_token(4, "18446744073709551616");
    ship();
    std_token(4, "0");
    ship();
    std_token(4, "0000000000000000000000007");
    ship();
    std_token(0, pick_chars(MAX_ISSUER + 1, TOK_SET));
    ship();
    std_token(5, pick_chars(SIG_HEX_LEN - 1, HEX_SET));
    ship();
    std_token(5, {pick_chars(SIG_HEX_LEN - 1, HEX_SET), "F"});
    ship();
    std_token(2, "");
    ship();
    std_token(1, "a=b");
    ship();
    // token characters that the payload alphabet rejects, then the reverse
    std_token(3, "p/q@r");
    ship();
    std_token(3, "a,b");
    ship();
    put("foo=1;");
    std_token(-1, "");
    ship();
    put("issuer=x;");
    std_token(-1, "");
    ship();
    std_token(-1, "");
    put(";aud=z");
    ship();
    std_token(-1, "");
    put(";;");
    ship();
    put(";");
    std_token(-1, "");
    ship();
    std_token(-1, "");
    put(";iss");
    ship();
    put("iss=a;sub=b;aud=c;proxy=d;exp=9");
    ship();
    std_token(0, "ab");
    payload_buf[5] = 8'h00;
    payload_buf[payload_buf.size() - 1] = 8'hFF;
    ship();
    put(";");
    ship();
    put("=");
    ship();
    payload_buf.push_back(8'hFF);
    ship();
    // payloads at and one past the size limit
    put("x=");
    while (payload_buf.size() < MAX_PAYLOAD) put("a");
    ship();
    put("x=");
    while (payload_buf.size() < MAX_PAYLOAD + 1) put("a");
    ship();
    hold_for_drain();

    rand_start = stream_q.size();
    i = 0;
    while (stream_q.size() < rand_start + 550) begin
      case ($urandom_range(0, 19))
        0, 1: rand_token(2);
        2, 3, 4, 5, 6: rand_token(1);
        default: rand_token(0);
      endcase
      i++;
      if (i == 3) hold_for_drain();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (stream_q.size() > 0 || in_valid || echo_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bytes sent in %0d payloads, %0d echo words checked",
             words_sent, n_payloads, words_seen);
    $display("verdicts seen: %0d accepted, %0d oversize, %0d malformed", n_ok, n_big, n_bad);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
